[hdl/sync_header_frame_checker_defines.svh]
// assertion macros for the sync header frame checker
// no dependencies; taken in by the files that carry assertions
`ifndef SYNC_HEADER_FRAME_CHECKER_DEFINES_SVH
`define SYNC_HEADER_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define SHFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shfc assertion failed");
// next-cycle implication, checked outside reset
`define SHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shfc assertion failed");
`else
`define SHFC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/shfc_pkg.sv]
// types and constants for the sync header frame checker
// no dependencies
package shfc_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h7E;
    localparam logic [7:0] SYNC_SECOND = 8'hE7;
    localparam logic [7:0] FORMAT_CODE = 8'hFF;

    localparam int unsigned PAYLOAD_BYTES_DEF = 2;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_SYNC2  = 3'd1,
        ST_FORMAT = 3'd2,
        ST_DATA   = 3'd3,
        ST_CHECK  = 3'd4
    } parse_state_t;

    typedef struct packed {
        logic        good;
        logic        bad;
        logic [15:0] payload;
    } result_t;

endpackage

[hdl/sync_header_frame_checker.sv]
// sync header frame checker: parser, additive checksum and two-deep output stage
// depends on shfc_pkg and sync_header_frame_checker_defines.svh
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, rx_byte           | into block
//  out     | out_valid, out_stall, frame_good,     | out of block
//          | frame_bad, payload                    |
//
// one byte per cycle while in_stall is low: each beat is parsed in the cycle it
// is taken and its result is registered in the output or skid register
// the output register plus a skid register decouple the two sides: in_stall
// rises only when both hold a result, and comes straight from a flop
// rst_n clears the parser to hunting with a zero sum and empties the output
`include "sync_header_frame_checker_defines.svh"

module sync_header_frame_checker #(
    parameter int unsigned PAYLOAD_BYTES = shfc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_good,
    output logic        frame_bad,
    output logic [15:0] payload
);

    shfc_pkg::parse_state_t state_reg, state_next;
    logic [7:0]             sum_reg, sum_next;
    logic [1:0]             count_reg, count_next;
    logic [15:0]            hold_reg, hold_next;
    shfc_pkg::result_t      res;

    logic                   main_valid_reg;
    shfc_pkg::result_t      main_reg;
    logic                   skid_valid_reg;
    shfc_pkg::result_t      skid_reg;

    logic                   in_take;
    logic                   out_take;

    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = main_valid_reg && !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        hold_next   = hold_reg;
        res         = '0;
        unique case (state_reg)
            shfc_pkg::ST_SYNC2:
            begin
                if (rx_byte == shfc_pkg::SYNC_SECOND)
                begin
                    sum_next   = sum_reg + rx_byte;
                    state_next = shfc_pkg::ST_FORMAT;
                end
                else
                begin
                    state_next = shfc_pkg::ST_HUNT;
                end
            end
            shfc_pkg::ST_FORMAT:
            begin
                if (rx_byte == shfc_pkg::FORMAT_CODE)
                begin
                    sum_next   = sum_reg + rx_byte;
                    state_next = shfc_pkg::ST_DATA;
                end
                else
                begin
                    state_next = shfc_pkg::ST_HUNT;
                end
            end
            shfc_pkg::ST_DATA:
            begin
                sum_next   = sum_reg + rx_byte;
                // first payload byte lands in the upper half
                if (count_reg == 2'd0)
                    hold_next = {rx_byte, hold_reg[7:0]};
                else
                    hold_next = {hold_reg[15:8], rx_byte};
                count_next = count_reg + 2'd1;
                if (count_next >= 2'(PAYLOAD_BYTES))
                    state_next = shfc_pkg::ST_CHECK;
            end
            shfc_pkg::ST_CHECK:
            begin
                res.good    = (sum_reg == rx_byte);
                res.bad     = (sum_reg != rx_byte);
                res.payload = hold_reg;
                state_next  = shfc_pkg::ST_HUNT;
            end
            default:
            begin
                // unused codes behave as hunting
                if (rx_byte == shfc_pkg::SYNC_FIRST)
                begin
                    sum_next   = shfc_pkg::SYNC_FIRST;
                    count_next = 2'd0;
                    hold_next  = '0;
                    state_next = shfc_pkg::ST_SYNC2;
                end
                else
                begin
                    state_next = shfc_pkg::ST_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shfc_pkg::ST_HUNT;
            sum_reg   <= '0;
            count_reg <= '0;
            hold_reg  <= '0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

    // output register with a skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_take;
            end
        end
        else if (in_take)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_take)
                main_reg <= res;
        end
        else if (in_take)
        begin
            if (main_valid_reg)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign frame_good = main_reg.good;
    assign frame_bad  = main_reg.bad;
    assign payload    = main_reg.payload;

    `SHFC_ASSERT_NOW(a_skid_needs_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    `SHFC_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_valid, !(frame_good && frame_bad))
    `SHFC_ASSERT_NOW(a_payload_only_with_flag, clk, rst_n,
        out_valid && !frame_good && !frame_bad, payload == 16'd0)
    `SHFC_ASSERT_NEXT(a_check_returns_to_hunt, clk, rst_n,
        in_take && (state_reg == shfc_pkg::ST_CHECK), state_reg == shfc_pkg::ST_HUNT)
    `SHFC_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_reg <= 2'(PAYLOAD_BYTES))

endmodule
